### rtl/braille_dot_canvas_line_draw_top_assert.svh
// Assertion macros shared by the braille dot canvas modules.
`ifndef BRAILLE_DOT_CANVAS_LINE_DRAW_TOP_ASSERT_SVH
`define BRAILLE_DOT_CANVAS_LINE_DRAW_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdc assertion failed");

`endif

### rtl/bdc_pkg.sv
// Types, constants and helper functions shared by the braille dot canvas modules.
`timescale 1ns / 1ps
package bdc_pkg;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_LINE   = 3'd4
  } op_t;

  localparam int CellW = 9;
  localparam logic [CellW-1:0] PatternBit = 9'h100;

  localparam logic [6:0] WidthReset  = 7'd64;
  localparam logic [5:0] HeightReset = 6'd32;

  // Register select is paddr[2]; the two low address bits are ignored.
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic [6:0] nx;
    logic [6:0] ny;
    logic       last;
    logic [7:0] visited;
  } step_stat_t;

  typedef struct packed {
    logic       dot_on;
    logic       in_range;
    logic [7:0] pixels_visited;
  } result_t;

  function automatic logic [7:0] dot_mask(input logic [1:0] yl, input logic xl);
    logic [7:0] m;
    case ({yl, xl})
      3'b000:  m = 8'h01;
      3'b001:  m = 8'h08;
      3'b010:  m = 8'h02;
      3'b011:  m = 8'h10;
      3'b100:  m = 8'h04;
      3'b101:  m = 8'h20;
      3'b110:  m = 8'h40;
      3'b111:  m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

### rtl/bdc_cell_mem.sv
// Single-port-per-direction cell memory with a registered read.
`timescale 1ns / 1ps
module bdc_cell_mem #(
  parameter int Depth,
  parameter int AddrW
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AddrW-1:0]         wr_addr,
  input  logic [bdc_pkg::CellW-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AddrW-1:0]         rd_addr,
  output logic [bdc_pkg::CellW-1:0] rd_data
);
  import bdc_pkg::*;

  logic [CellW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bdc_line_step.sv
// Incremental line stepper producing one pixel coordinate per advance.
`timescale 1ns / 1ps
`include "braille_dot_canvas_line_draw_top_assert.svh"
module bdc_line_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                advance,
  input  logic [6:0]          x_start,
  input  logic [6:0]          y_start,
  input  logic [6:0]          x_end,
  input  logic [6:0]          y_end,
  output bdc_pkg::step_stat_t step
);
  import bdc_pkg::*;

  logic       xup, yup;
  logic [6:0] xd, yd, r;
  logic [6:0] cx, cy, xd_q, yd_q, r_q, rem_x, rem_y, cnt;
  logic       xup_q, yup_q;
  logic [7:0] sum_x, sum_y;
  logic [6:0] nrem_x, nrem_y;

  always_comb begin
    xup = x_start <= x_end;
    yup = y_start <= y_end;
    xd  = xup ? x_end - x_start : x_start - x_end;
    yd  = yup ? y_end - y_start : y_start - y_end;
    r   = (xd > yd) ? xd : yd;

    sum_x = {1'b0, rem_x} + {1'b0, xd_q};
    sum_y = {1'b0, rem_y} + {1'b0, yd_q};
    step.nx = cx;
    step.ny = cy;
    nrem_x  = sum_x[6:0];
    nrem_y  = sum_y[6:0];
    if (sum_x >= {1'b0, r_q}) begin
      nrem_x  = 7'(sum_x - {1'b0, r_q});
      step.nx = xup_q ? cx + 7'd1 : cx - 7'd1;
    end
    if (sum_y >= {1'b0, r_q}) begin
      nrem_y  = 7'(sum_y - {1'b0, r_q});
      step.ny = yup_q ? cy + 7'd1 : cy - 7'd1;
    end
    step.last    = cnt == 7'd0;
    step.visited = {1'b0, r_q} + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_q   <= '0;
      rem_x <= '0;
      rem_y <= '0;
      cnt   <= '0;
      cx    <= '0;
      cy    <= '0;
      xd_q  <= '0;
      yd_q  <= '0;
      xup_q <= 1'b0;
      yup_q <= 1'b0;
    end else if (load) begin
      cx    <= x_start;
      cy    <= y_start;
      xd_q  <= xd;
      yd_q  <= yd;
      r_q   <= r;
      cnt   <= r;
      xup_q <= xup;
      yup_q <= yup;
      rem_x <= (xup || r == 7'd0) ? 7'd0 : r - 7'd1;
      rem_y <= (yup || r == 7'd0) ? 7'd0 : r - 7'd1;
    end else if (advance) begin
      cx    <= step.nx;
      cy    <= step.ny;
      rem_x <= nrem_x;
      rem_y <= nrem_y;
      cnt   <= cnt - 7'd1;
    end
  end

  `BDC_ASSERT_NOW(a_rem_below_r, clk, rst, r_q != 7'd0, (rem_x < r_q) && (rem_y < r_q))
  `BDC_ASSERT_NOW(a_no_step_past_end, clk, rst, advance, !step.last)

endmodule

### rtl/bdc_engine.sv
// Sequencer doing read-modify-write of canvas cells, with forwarding and result register.
`timescale 1ns / 1ps
`include "braille_dot_canvas_line_draw_top_assert.svh"
module bdc_engine #(
  parameter int MAX_CELL_COLS,
  parameter int MAX_CELL_ROWS,
  parameter int Depth,
  parameter int AddrW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [6:0]                width_cells,
  input  logic [5:0]                height_cells,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                op,
  input  logic [6:0]                x_start,
  input  logic [6:0]                y_start,
  input  bdc_pkg::step_stat_t       step,
  output logic                      step_load,
  output logic                      step_advance,
  output logic                      wr_en,
  output logic [AddrW-1:0]          wr_addr,
  output logic [bdc_pkg::CellW-1:0] wr_data,
  output logic                      rd_en,
  output logic [AddrW-1:0]          rd_addr,
  input  logic [bdc_pkg::CellW-1:0] rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output bdc_pkg::result_t          res
);
  import bdc_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MODIFY, ST_HOLD} state_t;

  state_t           state;
  logic [AddrW-1:0] clr_cnt;
  op_t              op_q;
  logic [AddrW-1:0] p_addr;
  logic [7:0]       p_mask;
  logic             p_inside, start_inside;
  logic             fwd_hit;
  logic [CellW-1:0] fwd_data;
  result_t          pend;

  logic [6:0]       ax, ay;
  logic [5:0]       col;
  logic [4:0]       row;
  logic             a_inside;
  logic [31:0]      a_full;
  logic [AddrW-1:0] a_addr;
  logic [7:0]       a_mask;

  logic [CellW-1:0] cur, set_val, clr_val, new_val;
  logic             cur_dot, new_dot, mod_wr, wr_mod, done, out_free, res_load;
  result_t          res_now;

  always_comb begin
    if (state == ST_IDLE) begin
      ax = x_start;
      ay = y_start;
    end else begin
      ax = step.nx;
      ay = step.ny;
    end
    col      = ax[6:1];
    row      = ay[6:2];
    a_inside = ({1'b0, col} < width_cells) && (32'(col) < MAX_CELL_COLS) &&
               ({1'b0, row} < height_cells) && (32'(row) < MAX_CELL_ROWS);
    a_full   = 32'(row) * 32'(MAX_CELL_COLS) + 32'(col);
    a_addr   = a_full[AddrW-1:0];
    a_mask   = dot_mask(ay[1:0], ax[0]);
  end

  always_comb begin
    cur     = fwd_hit ? fwd_data : rd_data;
    cur_dot = cur[8] && |(cur[7:0] & p_mask);
    set_val = (cur[8] ? cur : PatternBit) | {1'b0, p_mask};
    clr_val = cur[8] ? (cur & ~{1'b0, p_mask}) : cur;
    case (op_q)
      OP_SET, OP_LINE: begin
        new_val = set_val;
        mod_wr  = 1'b1;
      end
      OP_CLEAR: begin
        new_val = clr_val;
        mod_wr  = 1'b1;
      end
      OP_TOGGLE: begin
        new_val = cur_dot ? clr_val : set_val;
        mod_wr  = 1'b1;
      end
      default: begin
        new_val = cur;
        mod_wr  = 1'b0;
      end
    endcase
    new_dot = p_inside && new_val[8] && |(new_val[7:0] & p_mask);
    wr_mod  = (state == ST_MODIFY) && p_inside && mod_wr;
    done    = (state == ST_MODIFY) && ((op_q != OP_LINE) || step.last);

    res_now.dot_on         = (op_q == OP_LINE) ? 1'b0 : new_dot;
    res_now.in_range       = start_inside;
    res_now.pixels_visited = (op_q == OP_LINE) ? step.visited : 8'd0;

    out_free     = !res_valid || res_ready;
    res_load     = out_free && (done || (state == ST_HOLD));
    in_ready     = state == ST_IDLE;
    step_load    = (state == ST_IDLE) && in_valid;
    step_advance = (state == ST_MODIFY) && (op_q == OP_LINE) && !step.last;
    rd_en        = step_load || step_advance;
    rd_addr      = a_addr;

    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = wr_mod;
      wr_addr = p_addr;
      wr_data = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      fwd_hit  <= wr_mod && rd_en && (rd_addr == p_addr);
      fwd_data <= new_val;
      if (rd_en) begin
        p_addr   <= a_addr;
        p_mask   <= a_mask;
        p_inside <= a_inside;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AddrW'(1);
          if (clr_cnt == AddrW'(Depth - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_q         <= op_t'(op);
            start_inside <= a_inside;
            state        <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          if (done) begin
            if (out_free) begin
              res   <= res_now;
              state <= ST_IDLE;
            end else begin
              pend  <= res_now;
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            res   <= pend;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BDC_ASSERT_NOW(a_hold_has_result, clk, rst, state == ST_HOLD, res_valid)
  `BDC_ASSERT_NEXT(a_forward_taken, clk, rst, wr_mod && rd_en && (rd_addr == p_addr), fwd_hit)
  `BDC_ASSERT_NOW(a_forward_in_modify, clk, rst, fwd_hit, state == ST_MODIFY)

endmodule

### rtl/braille_dot_canvas_line_draw_top.sv
// Braille dot canvas with point operations and line drawing: top level.
//
// The canvas is held in one cell memory of MAX_CELL_COLS * MAX_CELL_ROWS
// nine-bit entries, read through a registered port and written back once for
// each pixel inside the canvas that a set, clear, toggle or line request
// touches. After reset a clearing pass writes every entry (2048 with the
// default sizes), during which no request is accepted; configuration writes
// are taken throughout. A point request reads its cell, then modifies it and,
// unless it is a query, writes it back. A line request first reads the start
// cell; each of the r + 1 pixels, where r is the larger axis difference, is
// then modified and written back while the cell of the next pixel is read,
// with the write of one pixel forwarded to the read of the next when both
// fall in the same cell. A finished result waits in an output register, so
// the next request can be accepted before it is taken.
`timescale 1ns / 1ps
module braille_dot_canvas_line_draw_top #(
  parameter int MAX_CELL_COLS = 64,
  parameter int MAX_CELL_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[2:0], x_start[9:3], y_start[16:10], x_end[23:17], y_end[30:24], zero[31]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // dot_on[0], in_range[1], pixels_visited[9:2], zero[15:10]
  output logic [15:0] m_tdata
);
  import bdc_pkg::*;

  localparam int Depth = MAX_CELL_COLS * MAX_CELL_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [6:0]       width_cells;
  logic [5:0]       height_cells;
  logic [2:0]       op;
  logic [6:0]       x_start, y_start, x_end, y_end;
  step_stat_t       step;
  logic             step_load, step_advance;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CellW-1:0] wr_data, rd_data;
  result_t          res;

  assign op      = s_tdata[2:0];
  assign x_start = s_tdata[9:3];
  assign y_start = s_tdata[16:10];
  assign x_end   = s_tdata[23:17];
  assign y_end   = s_tdata[30:24];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cells  <= WidthReset;
      height_cells <= HeightReset;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegWidth:  width_cells  <= pwdata[6:0];
        RegHeight: height_cells <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWidth:  prdata = {25'd0, width_cells};
      RegHeight: prdata = {26'd0, height_cells};
      default:   prdata = '0;
    endcase
  end

  bdc_cell_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bdc_line_step u_step (
    .clk     (clk),
    .rst     (rst),
    .load    (step_load),
    .advance (step_advance),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .step    (step)
  );

  bdc_engine #(
    .MAX_CELL_COLS (MAX_CELL_COLS),
    .MAX_CELL_ROWS (MAX_CELL_ROWS),
    .Depth         (Depth),
    .AddrW         (AddrW)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .width_cells  (width_cells),
    .height_cells (height_cells),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .op           (op),
    .x_start      (x_start),
    .y_start      (y_start),
    .step         (step),
    .step_load    (step_load),
    .step_advance (step_advance),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res          (res)
  );

  assign m_tdata = {6'd0, res.pixels_visited, res.in_range, res.dot_on};

endmodule
